@@ design/slkc_pkg.sv @@
`timescale 1ns / 1ps

package slkc_pkg;

  // Field widths
  localparam int CODE_BITS  = 3;
  localparam int KEY_BITS   = 7;
  localparam int POS_BITS   = 7;
  localparam int LEN_BITS   = 8;
  localparam int COLOR_BITS = 24;
  localparam int CFG_BITS   = 32;
  localparam int CFG_IDX_BITS = 3;

  // Status codes
  localparam logic [CODE_BITS-1:0] ST_OFF  = 3'd0;
  localparam logic [CODE_BITS-1:0] ST_OK   = 3'd1;
  localparam logic [CODE_BITS-1:0] ST_WARN = 3'd2;
  localparam logic [CODE_BITS-1:0] ST_FAIL = 3'd3;
  localparam logic [CODE_BITS-1:0] ST_BUSY = 3'd4;

  // Animation styles
  localparam logic [1:0] STY_SOLID     = 2'd0;
  localparam logic [1:0] STY_PULSE     = 2'd1;
  localparam logic [1:0] STY_SWEEP     = 2'd2;
  localparam logic [1:0] STY_SOLID_ALT = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_OFF_COLOR  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OK_COLOR   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WARN_COLOR = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAIL_COLOR = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BUSY_COLOR = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_STYLES     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_OK_TIMEOUT = 3'd6;

  // Register reset values
  localparam logic [COLOR_BITS-1:0] RST_OFF_COLOR  = 24'h000000;
  localparam logic [COLOR_BITS-1:0] RST_OK_COLOR   = 24'h00DC50;
  localparam logic [COLOR_BITS-1:0] RST_WARN_COLOR = 24'hF0B400;
  localparam logic [COLOR_BITS-1:0] RST_FAIL_COLOR = 24'hFF1E14;
  localparam logic [COLOR_BITS-1:0] RST_BUSY_COLOR = 24'hFF9600;
  localparam logic [7:0]            RST_STYLES     = 8'h94;
  localparam logic [CFG_BITS-1:0]   RST_OK_TIMEOUT = 32'd0;

  localparam logic [COLOR_BITS-1:0] GRAY_COLOR = 24'h787878;

  // Intensity in Q1.16
  localparam int INT_BITS = 17;
  localparam logic [INT_BITS-1:0] Q16_ONE = 17'h10000;

  // Pulse: phase step per ms in Q0.48 turns, split for two narrow products
  localparam longint unsigned TURN_STEP_Q48 = 64'd223990669501;
  localparam int STEP_LO_BITS = 24;
  localparam logic [23:0] STEP_LO = 24'(TURN_STEP_Q48 & 64'hFFFFFF);
  localparam logic [13:0] STEP_HI = 14'(TURN_STEP_Q48 >> STEP_LO_BITS);
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_BITS = $clog2(SINE_ENTRIES);
  localparam logic [31:0] PULSE_BASE = 32'(44237 * 32768);
  localparam logic [15:0] PULSE_GAIN = 16'd21299;
  localparam int PULSE_ROUND = 16384;

  // Sweep: period fold and reciprocal constants
  localparam int SWEEP_PERIOD = 1250;
  localparam int FOLD_MUL = (1 << 16) % SWEEP_PERIOD;
  localparam int MOD_SHIFT = 37;
  localparam logic [26:0] MOD_RECIP =
    27'(((64'd1 << MOD_SHIFT) + SWEEP_PERIOD - 1) / SWEEP_PERIOD);
  localparam int HEAD_SHIFT = 22;
  localparam logic [27:0] HEAD_RECIP =
    28'(((64'd1 << 38) + SWEEP_PERIOD - 1) / SWEEP_PERIOD);
  localparam int RECIP_SHIFT = 31;
  localparam int POS_SHIFT = RECIP_SHIFT - 16;
  localparam logic [INT_BITS-1:0] SWEEP_FLOOR = 17'd7864;
  localparam logic [19:0] SWEEP_KNEE = 20'(65536 - 7864);

  // Fade divider
  localparam int FADE_STAGES = 17;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PIHALF_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [CODE_BITS-1:0] status_code;
    logic [31:0]          time_ms;
    logic [31:0]          age_ms;
    logic [POS_BITS-1:0]  run_position;
    logic [LEN_BITS-1:0]  run_length;
    logic [KEY_BITS-1:0]  key_address;
  } item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key_out;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
  } result_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] off_color;
    logic [COLOR_BITS-1:0] ok_color;
    logic [COLOR_BITS-1:0] warn_color;
    logic [COLOR_BITS-1:0] fail_color;
    logic [COLOR_BITS-1:0] busy_color;
    logic [7:0]            style_codes;
    logic [CFG_BITS-1:0]   ok_timeout_ms;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COLOR_BITS-1:0] color;
    logic [INT_BITS-1:0]   inten;
    logic                  fade;
    logic [31:0]           num;
    logic [31:0]           den;
  } work_t;

  // Sine in Q1.15, Taylor series in Q30 on the quarter wave
  function automatic logic signed [15:0] sine_entry(input int unsigned k);
    longint unsigned a, q, r, th, t2, acc, v;
    logic signed [15:0] rv;
    a = 4 * longint'(k);
    q = a / SINE_ENTRIES;
    r = a % SINE_ENTRIES;
    if ((q & 1) != 0) r = SINE_ENTRIES - r;
    th = (r * PIHALF_Q30) / SINE_ENTRIES;
    t2 = (th * th) >> 30;
    acc = Q30_ONE;
    acc = Q30_ONE - ((t2 * acc) >> 30) / 72;
    acc = Q30_ONE - ((t2 * acc) >> 30) / 42;
    acc = Q30_ONE - ((t2 * acc) >> 30) / 20;
    acc = Q30_ONE - ((t2 * acc) >> 30) / 6;
    v = (((th * acc) >> 30) + 16384) >> 15;
    if (v > 32767) v = 32767;
    rv = 16'(v);
    if (q >= 2) rv = -rv;
    return rv;
  endfunction

endpackage

@@ design/slkc_front.sv @@
`timescale 1ns / 1ps

module slkc_front import slkc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    push,
  output work_t   push_data,
  input  logic    queue_full
);

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COLOR_BITS-1:0] color;
    logic [1:0]            style;
    logic                  zero;
    logic                  fade;
    logic [31:0]           num;
    logic [31:0]           den;
  } ctl_t;

  // Constant tables
  logic [31:0]        recip [256];
  logic signed [15:0] sine_tab [SINE_ENTRIES];

  for (genvar g = 0; g < 256; g++) begin : g_recip
    localparam longint unsigned RV =
      (g == 0) ? 0 : ((64'd1 << RECIP_SHIFT) + g - 1) / ((g == 0) ? 1 : g);
    assign recip[g] = 32'(RV);
  end

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_sine
    localparam logic signed [15:0] SV = sine_entry(g);
    assign sine_tab[g] = SV;
  end

  logic adv;
  logic v1, v2, v3, v4, v5, v6;
  ctl_t c1, c2, c3, c4, c5;

  logic [55:0] plo1;
  logic [23:0] phi1;
  logic [25:0] fold1, fold2;
  logic [POS_BITS-1:0] p1;
  logic [LEN_BITS-1:0] m1;
  logic [SINE_BITS-1:0] idx2;
  logic [14:0] q2;
  logic [16:0] pos2, pos3, pos4;
  logic signed [15:0] s3;
  logic [10:0] r3;
  logic signed [31:0] pp4;
  logic [15:0] head4;
  logic [INT_BITS-1:0] pulse5, d5;
  work_t w6;

  assign adv = !(v6 && queue_full);
  assign item_stall = !adv;
  assign push = v6 && !queue_full;
  assign push_data = w6;

  // Stage 1: classify, clamp the run position and start the phase and fold products
  ctl_t c1_next;
  logic [LEN_BITS-1:0] m_next;
  logic [POS_BITS-1:0] p_next;
  always_comb begin
    c1_next.key  = item.key_address;
    c1_next.num  = cfg.ok_timeout_ms - item.age_ms;
    c1_next.den  = cfg.ok_timeout_ms;
    c1_next.fade = (item.status_code == ST_OK) && (cfg.ok_timeout_ms != '0);
    c1_next.zero = (item.status_code == ST_OFF) ||
                   (c1_next.fade && (item.age_ms > cfg.ok_timeout_ms));
    unique case (item.status_code)
      ST_OK: begin
        c1_next.color = cfg.ok_color;
        c1_next.style = cfg.style_codes[1:0];
      end
      ST_WARN: begin
        c1_next.color = cfg.warn_color;
        c1_next.style = cfg.style_codes[3:2];
      end
      ST_FAIL: begin
        c1_next.color = cfg.fail_color;
        c1_next.style = cfg.style_codes[5:4];
      end
      ST_BUSY: begin
        c1_next.color = cfg.busy_color;
        c1_next.style = cfg.style_codes[7:6];
      end
      default: begin
        c1_next.color = GRAY_COLOR;
        c1_next.style = STY_SOLID;
      end
    endcase
    // run length of 0 or 1 places every key at the start
    m_next = (item.run_length > LEN_BITS'(1)) ? item.run_length - LEN_BITS'(1) : '0;
    p_next = ({1'b0, item.run_position} > m_next) ? m_next[POS_BITS-1:0]
                                                 : item.run_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  // Stage 2 inputs
  logic [47:0] frac;
  logic [52:0] qprod;
  logic [38:0] posprod;
  always_comb begin
    frac = plo1[47:0] + {phi1, 24'd0};
    qprod = 53'(fold1) * 53'(MOD_RECIP);
    posprod = 39'(p1) * 39'(recip[m1]);
  end

  // Stage 5 inputs: pulse level and sweep distance
  logic signed [31:0] u5;
  logic [INT_BITS-1:0] pulse_next, d_raw, d_alt;
  always_comb begin
    u5 = $signed(PULSE_BASE) + pp4 + 32'sd16384;
    pulse_next = INT_BITS'(u5 >>> 15);
    if (pulse_next > Q16_ONE) pulse_next = Q16_ONE;
    d_raw = (pos4 > 17'(head4)) ? pos4 - 17'(head4) : 17'(head4) - pos4;
    d_alt = Q16_ONE - d_raw;
  end

  // Stage 6 inputs: final intensity
  logic [19:0] d5x5;
  logic [INT_BITS-1:0] sweep_int, inten6;
  always_comb begin
    d5x5 = 20'(d5) * 20'd5;
    sweep_int = (d5x5 >= SWEEP_KNEE) ? SWEEP_FLOOR : INT_BITS'(20'd65536 - d5x5);
    if (c5.zero) inten6 = '0;
    else begin
      unique case (c5.style)
        STY_PULSE: inten6 = pulse5;
        STY_SWEEP: inten6 = sweep_int;
        default:   inten6 = Q16_ONE;
      endcase
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      c1    <= c1_next;
      plo1  <= 56'(item.time_ms) * 56'(STEP_LO);
      phi1  <= item.time_ms[23:0] * 24'(STEP_HI);
      fold1 <= 26'(item.time_ms[31:16]) * 26'(FOLD_MUL) + 26'(item.time_ms[15:0]);
      p1    <= p_next;
      m1    <= m_next;

      c2    <= c1;
      idx2  <= frac[47 -: SINE_BITS];
      q2    <= 15'(qprod >> MOD_SHIFT);
      pos2  <= 17'(posprod >> POS_SHIFT);
      fold2 <= fold1;

      c3    <= c2;
      s3    <= sine_tab[idx2];
      r3    <= 11'(fold2 - 26'(q2) * 26'(SWEEP_PERIOD));
      pos3  <= pos2;

      c4    <= c3;
      pp4   <= $signed({16'd0, PULSE_GAIN}) * 32'(s3);
      head4 <= 16'((39'(r3) * 39'(HEAD_RECIP)) >> HEAD_SHIFT);
      pos4  <= pos3;

      c5     <= c4;
      pulse5 <= pulse_next;
      d5     <= (d_alt < d_raw) ? d_alt : d_raw;

      w6.key   <= c5.key;
      w6.color <= c5.color;
      w6.inten <= inten6;
      w6.fade  <= c5.fade && !c5.zero;
      w6.num   <= c5.num;
      w6.den   <= c5.den;
    end
  end

endmodule

@@ design/slkc_queue.sv @@
`timescale 1ns / 1ps

module slkc_queue import slkc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output work_t head
);

  work_t store [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) store[wr_ptr] <= push_data;
  end

endmodule

@@ design/slkc_back.sv @@
`timescale 1ns / 1ps

module slkc_back import slkc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic [COLOR_BITS-1:0] off_color,
  input  logic     queue_empty,
  input  work_t    head,
  output logic     pop,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [COLOR_BITS-1:0] color;
    logic [INT_BITS-1:0]   inten;
    logic                  fade;
    logic [31:0]           den;
    logic [32:0]           rem;
    logic [FADE_STAGES-1:0] quot;
  } div_t;

  // One restoring step: one more fraction bit of the fade
  function automatic div_t div_step(input div_t d);
    div_t o;
    logic [32:0] r2;
    o = d;
    r2 = {d.rem[31:0], 1'b0};
    if (r2 >= {1'b0, d.den}) begin
      o.rem  = r2 - {1'b0, d.den};
      o.quot = {d.quot[FADE_STAGES-2:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.quot = {d.quot[FADE_STAGES-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [7:0] mix(input logic [7:0] o, input logic [7:0] c,
                                     input logic [INT_BITS-1:0] t);
    logic signed [8:0]  diff;
    logic signed [26:0] acc;
    diff = $signed({1'b0, c}) - $signed({1'b0, o});
    acc = $signed({3'b0, o, 16'd0}) + 27'(diff) * $signed({10'd0, t}) + 27'sd32768;
    return acc[23:16];
  endfunction

  logic adv;
  logic dv [FADE_STAGES];
  div_t ds [FADE_STAGES];
  logic fv;
  logic [KEY_BITS-1:0] fkey;
  logic [COLOR_BITS-1:0] fcolor;
  logic [INT_BITS-1:0] ft;

  assign adv = !(result_valid && result_stall);
  assign pop = adv && !queue_empty;

  // Integer bit of the fade: set when num reaches den, as at age zero
  div_t d0;
  always_comb begin
    d0.key   = head.key;
    d0.color = head.color;
    d0.inten = head.inten;
    d0.fade  = head.fade;
    d0.den   = head.den;
    if (head.num >= head.den) begin
      d0.rem  = 33'(head.num - head.den);
      d0.quot = FADE_STAGES'(1);
    end else begin
      d0.rem  = 33'(head.num);
      d0.quot = '0;
    end
  end

  // Fade applied to intensity
  logic [33:0] fprod;
  logic [INT_BITS-1:0] t_next;
  always_comb begin
    fprod = 34'(ds[FADE_STAGES-1].inten) * 34'(ds[FADE_STAGES-1].quot);
    t_next = ds[FADE_STAGES-1].fade ? INT_BITS'(fprod >> 16) : ds[FADE_STAGES-1].inten;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FADE_STAGES; k++) dv[k] <= 1'b0;
      fv <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      dv[0] <= !queue_empty;
      for (int k = 1; k < FADE_STAGES; k++) dv[k] <= dv[k-1];
      fv <= dv[FADE_STAGES-1];
      result_valid <= fv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0] <= d0;
      for (int k = 1; k < FADE_STAGES; k++) ds[k] <= div_step(ds[k-1]);
      fkey   <= ds[FADE_STAGES-1].key;
      fcolor <= ds[FADE_STAGES-1].color;
      ft     <= t_next;
      result.key_out <= fkey;
      result.red   <= mix(off_color[23:16], fcolor[23:16], ft);
      result.green <= mix(off_color[15:8],  fcolor[15:8],  ft);
      result.blue  <= mix(off_color[7:0],   fcolor[7:0],   ft);
    end
  end

endmodule

@@ design/status_light_key_color.sv @@
`timescale 1ns / 1ps
// Status key color generator.
// Input channel item_valid / item_stall / item carries one key: status code,
// animation time, status age, place in the lit run, run length, key address.
// Output channel result_valid / result_stall / result gives the key address
// and the RGB888 color mixed from the off color toward the status color.
// A transfer happens at a clock edge with valid high and stall low.
// Throughput: one key per cycle unless stalled. The front pipeline (6 stages)
// works out the animation intensity; the back pipeline runs a 17-stage
// restoring divider for the ok fade, then the fade product and the mix.
// From input transfer to result valid a key passes the 6 front stages,
// the 4-entry queue, the 17 divider stages and the fade and mix registers.
// When the receiver stalls, the back pipeline holds; the front keeps
// accepting until the queue is full, then stalls the input.
// Reset (rst, synchronous) empties both pipelines and the queue and loads
// the register defaults. Registers are written through cfg_write, cfg_index
// and cfg_data; the user writes them only while no key is in flight (unchecked).
module status_light_key_color import slkc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  item_t                   item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output result_t                 result,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  cfg_t  cfg;
  logic  push, queue_full, pop, queue_empty;
  work_t push_data, head;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_color     <= RST_OFF_COLOR;
      cfg.ok_color      <= RST_OK_COLOR;
      cfg.warn_color    <= RST_WARN_COLOR;
      cfg.fail_color    <= RST_FAIL_COLOR;
      cfg.busy_color    <= RST_BUSY_COLOR;
      cfg.style_codes   <= RST_STYLES;
      cfg.ok_timeout_ms <= RST_OK_TIMEOUT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OFF_COLOR:  cfg.off_color     <= cfg_data[COLOR_BITS-1:0];
        REG_OK_COLOR:   cfg.ok_color      <= cfg_data[COLOR_BITS-1:0];
        REG_WARN_COLOR: cfg.warn_color    <= cfg_data[COLOR_BITS-1:0];
        REG_FAIL_COLOR: cfg.fail_color    <= cfg_data[COLOR_BITS-1:0];
        REG_BUSY_COLOR: cfg.busy_color    <= cfg_data[COLOR_BITS-1:0];
        REG_STYLES:     cfg.style_codes   <= cfg_data[7:0];
        REG_OK_TIMEOUT: cfg.ok_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  slkc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  slkc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .empty     (queue_empty),
    .head      (head)
  );

  slkc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .off_color    (cfg.off_color),
    .queue_empty  (queue_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

@@ design/slkc_check.sv @@
`timescale 1ns / 1ps

module slkc_check import slkc_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    item_valid,
  input logic                    item_stall,
  input item_t                   item,
  input logic                    result_valid,
  input logic                    result_stall,
  input result_t                 result,
  input logic                    cfg_write,
  input logic [CFG_IDX_BITS-1:0] cfg_index,
  input logic [CFG_BITS-1:0]     cfg_data
);

  // Reset leaves the output side empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // Reset leaves the input side open
  a_reset_open: assert property (@(posedge clk) rst |=> !item_stall)
    else $error("input stalled right after reset");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // A stalled input holds its payload
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("stalled input changed");

  // Register writes carry a known index and value
  a_cfg_known: assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> !$isunknown({cfg_index, cfg_data}))
    else $error("register write with unknown index or data");

endmodule

bind status_light_key_color slkc_check u_check (.*);
